// ===== rtl/fgg_pkg.sv =====
package fgg_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH      = 3'd0,
		REG_FRAME_HEIGHT     = 3'd1,
		REG_UPSAMPLING_SHIFT = 3'd2,
		REG_LF_LEVEL         = 3'd3,
		REG_GROUP_SIZE_SHIFT = 3'd4
	} cfg_reg_t;

	localparam int DIV_STAGES = 8;   // divider pipeline stages
	localparam int DIV_STEP   = 4;   // quotient bits per stage
	localparam int STRIDE_W   = 24;  // groups per row fit below 2^24

	// frame geometry derived from the registers
	typedef struct packed {
		logic                zero;    // no columns at all
		logic [1:0]          gs;      // group size shift
		logic [29:0]         sw;
		logic [29:0]         sh;
		logic [STRIDE_W-1:0] gpr;     // group columns
		logic [STRIDE_W-1:0] grows;   // group rows
		logic [STRIDE_W-1:0] lgpr;    // LF group columns
		logic [STRIDE_W-1:0] lgrows;  // LF group rows
		logic [STRIDE_W-1:0] fc;      // full group columns
		logic [9:0]          cr;      // right edge remainder
		logic [STRIDE_W-1:0] fr;
		logic [9:0]          rr;
		logic [STRIDE_W-1:0] lfc;
		logic [12:0]         lcr;
		logic [STRIDE_W-1:0] lfr;
		logic [12:0]         lrr;
	} geo_t;

	// everything the output stage needs besides the quotients and remainders
	typedef struct packed {
		geo_t        geo;
		logic [31:0] ng;
		logic [31:0] nlg;
		logic [31:0] sidx;
		logic        cok;
		logic [31:0] cidx;
	} fin_t;

endpackage

// ===== rtl/frame_group_geometry.sv =====
// Frame group geometry: tiling of a frame into groups and LF groups.
// Configuration: write cfg_data to register cfg_index with cfg_valid; cfg_ready
// is always high. Indexes 0..4 are frame width, frame height, upsampling shift,
// LF level and group size shift; other indexes are ignored. Write only while
// no query is in flight.
// Query channel (req_*): one item per cycle while req_stall is low, carrying
// group_index, lf_group_index, pass_index, pixel_x and pixel_y. Result channel
// (rsp_*): one item per query, in order.
// Throughput is one item per cycle while the result is not stalled. The depth
// is set by the two 32-bit dividers (group index by groups per row, LF group
// index by LF groups per row), eight stages of four quotient bits each.
// All stages advance together; when the result is stalled the whole pipe
// holds and req_stall is raised, nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values (group
// size shift 1, everything else 0).
module frame_group_geometry import fgg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [29:0] cfg_data,
	// query
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [31:0] group_index,
	input  logic [31:0] lf_group_index,
	input  logic [3:0]  pass_index,
	input  logic [29:0] pixel_x,
	input  logic [29:0] pixel_y,
	// result
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [10:0] group_width,
	output logic [10:0] group_height,
	output logic [31:0] lf_group_of_group,
	output logic [13:0] lf_group_width,
	output logic [13:0] lf_group_height,
	output logic [31:0] coord_group_index,
	output logic        coord_in_range,
	output logic [31:0] stream_index,
	output logic [29:0] sample_width,
	output logic [29:0] sample_height,
	output logic [31:0] group_count,
	output logic [31:0] lf_group_count
);

	localparam int LAT = DIV_STAGES + 2;

	logic [29:0] fw_q, fh_q;
	logic [1:0]  us_q, gs_q;
	logic [2:0]  lf_q;
	logic        en;
	logic [LAT:1] vld_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0;
			fh_q <= '0;
			us_q <= '0;
			lf_q <= '0;
			gs_q <= 2'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:      fw_q <= cfg_data;
				REG_FRAME_HEIGHT:     fh_q <= cfg_data;
				REG_UPSAMPLING_SHIFT: us_q <= cfg_data[1:0];
				REG_LF_LEVEL:         lf_q <= cfg_data[2:0];
				REG_GROUP_SIZE_SHIFT: gs_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// global advance
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], req_valid};
		end
	end

	// geometry from the registers, both reductions round up
	geo_t geo_c;
	logic [22:0] gx_c, gy_c;
	always_comb begin
		logic [31:0] um, lm, gm, lgm, w0, h0, w1, h1;
		logic [4:0]  ls;
		logic [3:0]  g7, g10;
		um  = (32'd1 << us_q) - 32'd1;
		ls  = 5'(3 * lf_q);
		lm  = (32'd1 << ls) - 32'd1;
		g7  = 4'd7 + {2'b0, gs_q};
		g10 = 4'd10 + {2'b0, gs_q};
		gm  = (32'd1 << g7) - 32'd1;
		lgm = (32'd1 << g10) - 32'd1;
		w0  = ({2'b0, fw_q} + um) >> us_q;
		h0  = ({2'b0, fh_q} + um) >> us_q;
		w1  = (w0 + lm) >> ls;
		h1  = (h0 + lm) >> ls;
		geo_c.sw     = w1[29:0];
		geo_c.sh     = h1[29:0];
		geo_c.zero   = (w1 == 32'd0);
		geo_c.gs     = gs_q;
		geo_c.gpr    = STRIDE_W'((w1 + gm) >> g7);
		geo_c.grows  = STRIDE_W'((h1 + gm) >> g7);
		geo_c.lgpr   = STRIDE_W'((w1 + lgm) >> g10);
		geo_c.lgrows = STRIDE_W'((h1 + lgm) >> g10);
		geo_c.fc     = STRIDE_W'(w1 >> g7);
		geo_c.cr     = 10'(w1 & gm);
		geo_c.fr     = STRIDE_W'(h1 >> g7);
		geo_c.rr     = 10'(h1 & gm);
		geo_c.lfc    = STRIDE_W'(w1 >> g10);
		geo_c.lcr    = 13'(w1 & lgm);
		geo_c.lfr    = STRIDE_W'(h1 >> g10);
		geo_c.lrr    = 13'(h1 & lgm);
		gx_c = 23'(pixel_x >> g7);
		gy_c = 23'(pixel_y >> g7);
	end

	// stage 1: capture query and geometry
	geo_t        geo_s1;
	logic [31:0] gi_s1, lgi_s1;
	logic [3:0]  pass_s1;
	logic [22:0] gx_s1, gy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1  <= geo_c;
			gi_s1   <= group_index;
			lgi_s1  <= lf_group_index;
			pass_s1 <= pass_index;
			gx_s1   <= gx_c;
			gy_s1   <= gy_c;
		end
	end

	// stage 2: counts and coordinate product
	geo_t        geo_s2;
	logic [31:0] gi_s2, ng_s2, nlg_s2, cg_s2;
	logic [3:0]  pass_s2;
	logic        gxok_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2  <= geo_s1;
			gi_s2   <= gi_s1;
			pass_s2 <= pass_s1;
			ng_s2   <= 32'(geo_s1.gpr * geo_s1.grows);
			nlg_s2  <= 32'(geo_s1.lgpr * geo_s1.lgrows);
			cg_s2   <= 32'({1'b0, gy_s1} * geo_s1.gpr) + {9'd0, gx_s1};
			gxok_s2 <= ({1'b0, gx_s1} < geo_s1.gpr);
		end
	end

	// stage 3: stream index terms, coordinate check
	geo_t        geo_s3;
	logic [31:0] ng_s3, nlg_s3, pm_s3, tn_s3, cidx_s3;
	logic        cok_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3  <= geo_s2;
			ng_s3   <= ng_s2;
			nlg_s3  <= nlg_s2;
			pm_s3   <= 32'(pass_s2 * ng_s2);
			tn_s3   <= 32'(nlg_s2 * 3) + 32'd18 + gi_s2;
			cok_s3  <= gxok_s2 && (cg_s2 < ng_s2);
			cidx_s3 <= (gxok_s2 && (cg_s2 < ng_s2)) ? cg_s2 : 32'd0;
		end
	end

	// stages 4 to 9: align with the dividers
	fin_t fin_s [4:LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			fin_s[4].geo  <= geo_s3;
			fin_s[4].ng   <= ng_s3;
			fin_s[4].nlg  <= nlg_s3;
			fin_s[4].sidx <= pm_s3 + tn_s3;
			fin_s[4].cok  <= cok_s3;
			fin_s[4].cidx <= cidx_s3;
			for (int k = 5; k < LAT; k++) begin
				fin_s[k] <= fin_s[k-1];
			end
		end
	end

	// row and column of the group and the LF group
	logic [31:0]         gq, lq;
	logic [STRIDE_W-1:0] grm, lrm;

	fgg_div u_gdiv (
		.clk      (clk),
		.en       (en),
		.dividend (gi_s1),
		.divisor  (geo_s1.gpr),
		.quo      (gq),
		.rem      (grm)
	);

	fgg_div u_ldiv (
		.clk      (clk),
		.en       (en),
		.dividend (lgi_s1),
		.divisor  (geo_s1.lgpr),
		.quo      (lq),
		.rem      (lrm)
	);

	// stage 10: tile sizes and LF group of group, output register
	fin_t        f;
	logic [10:0] gd;
	logic [13:0] lgd;
	assign f   = fin_s[LAT-1];
	assign gd  = 11'd128 << f.geo.gs;
	assign lgd = 14'd1024 << f.geo.gs;

	always_ff @(posedge clk) begin
		if (en) begin
			if (f.geo.zero) begin
				group_width       <= '0;
				group_height      <= '0;
				lf_group_width    <= '0;
				lf_group_height   <= '0;
				lf_group_of_group <= '0;
			end else begin
				group_width     <= (grm >= f.geo.fc) ? {1'b0, f.geo.cr} : gd;
				group_height    <= (gq >= {8'd0, f.geo.fr}) ? {1'b0, f.geo.rr} : gd;
				lf_group_width  <= (lrm >= f.geo.lfc) ? {1'b0, f.geo.lcr} : lgd;
				lf_group_height <= (lq >= {8'd0, f.geo.lfr}) ? {1'b0, f.geo.lrr} : lgd;
				lf_group_of_group <= {11'd0, grm[STRIDE_W-1:3]}
					+ 32'({3'd0, gq[31:3]} * f.geo.lgpr);
			end
			coord_group_index <= f.cidx;
			coord_in_range    <= f.cok;
			stream_index      <= f.sidx;
			sample_width      <= f.geo.sw;
			sample_height     <= f.geo.sh;
			group_count       <= f.ng;
			lf_group_count    <= f.nlg;
		end
	end

	assign rsp_valid = vld_q[LAT];

	// a held result must freeze the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("result stalled but query accepted");

	// coordinate outside any group reports index zero
	a_coord_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !coord_in_range |-> coord_group_index == 32'd0)
		else $error("coordinate index set without range flag");

	// empty frame gives empty tiles
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sample_width == 30'd0 |->
		group_width == 11'd0 && lf_group_width == 14'd0 && !coord_in_range)
		else $error("nonzero tile for empty frame");

	// a stalled pipe keeps its valid bits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(rsp_valid && rsp_stall) |-> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule

// ===== rtl/fgg_div.sv =====
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module fgg_div import fgg_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         dividend,
	input  logic [STRIDE_W-1:0] divisor,
	output logic [31:0]         quo,
	output logic [STRIDE_W-1:0] rem
);

	logic [STRIDE_W-1:0] rem_s [DIV_STAGES];
	logic [31:0]         num_s [DIV_STAGES];
	logic [STRIDE_W-1:0] dvs_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [STRIDE_W-1:0] r_in;
		logic [31:0]         n_in;
		logic [STRIDE_W-1:0] d_in;
		logic [STRIDE_W-1:0] r_nx;
		logic [31:0]         n_nx;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign n_in = dividend;
			assign d_in = divisor;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign n_in = num_s[k-1];
			assign d_in = dvs_s[k-1];
		end

		// shift in one dividend bit per step, quotient bits fill from the bottom
		always_comb begin
			logic [STRIDE_W:0] t;
			logic [STRIDE_W-1:0] r;
			logic [31:0] n;
			r = r_in;
			n = n_in;
			for (int j = 0; j < DIV_STEP; j++) begin
				t = {r, n[31]};
				n = {n[30:0], 1'b0};
				if (t >= {1'b0, d_in}) begin
					t = t - {1'b0, d_in};
					n[0] = 1'b1;
				end
				r = t[STRIDE_W-1:0];
			end
			r_nx = r;
			n_nx = n;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				num_s[k] <= n_nx;
				dvs_s[k] <= d_in;
			end
		end
	end

	assign quo = num_s[DIV_STAGES-1];
	assign rem = rem_s[DIV_STAGES-1];

endmodule
